// ===== sv/crb_pkg.sv =====
`timescale 1ns / 1ps

package crb_pkg;

  localparam int CRB_RING_DEPTH    = 128;
  localparam int CRB_CHANNEL_COUNT = 3;

  localparam int OP_W   = 2;
  localparam int CHAN_W = 2;
  localparam int BYTE_W = 8;

  localparam logic [OP_W-1:0] OP_PUSH  = 2'd0;
  localparam logic [OP_W-1:0] OP_POP   = 2'd1;
  localparam logic [OP_W-1:0] OP_FLUSH = 2'd2;

  typedef struct packed {
    logic got_byte;
    logic dropped;
    logic not_empty;
  } crb_flags_t;

endpackage

// ===== sv/crb_if.sv =====
`timescale 1ns / 1ps

interface crb_in_if import crb_pkg::*;;
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [CHAN_W-1:0] channel;
  logic [BYTE_W-1:0] received_byte;

  modport source (output valid, output op, output channel, output received_byte, input ready);
  modport sink   (input valid, input op, input channel, input received_byte, output ready);
endinterface

interface crb_out_if import crb_pkg::*;;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] byte_out;
  logic              got_byte;
  logic              dropped;
  logic              not_empty;

  modport source (output valid, output byte_out, output got_byte, output dropped,
                  output not_empty, input ready);
  modport sink   (input valid, input byte_out, input got_byte, input dropped,
                  input not_empty, output ready);
endinterface

// ===== sv/crb_ring_mem.sv =====
`timescale 1ns / 1ps

module crb_ring_mem import crb_pkg::*; #(
  parameter int RING_DEPTH    = CRB_RING_DEPTH,
  parameter int CHANNEL_COUNT = CRB_CHANNEL_COUNT,
  localparam int MemDepth     = RING_DEPTH * CHANNEL_COUNT,
  localparam int AddrW        = $clog2(MemDepth)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic              re_i,
  input  logic [AddrW-1:0]  addr_i,
  input  logic [BYTE_W-1:0] wdata_i,
  output logic [BYTE_W-1:0] rdata_o
);

  logic [BYTE_W-1:0] mem [MemDepth];
  logic [BYTE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/crb_ptr_ctrl.sv =====
`timescale 1ns / 1ps

module crb_ptr_ctrl import crb_pkg::*; #(
  parameter int RING_DEPTH    = CRB_RING_DEPTH,
  parameter int CHANNEL_COUNT = CRB_CHANNEL_COUNT,
  localparam int PtrW         = $clog2(RING_DEPTH),
  localparam int IdxW         = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1,
  localparam int AddrW        = $clog2(RING_DEPTH * CHANNEL_COUNT)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic [OP_W-1:0]   op_i,
  input  logic [CHAN_W-1:0] channel_i,
  output logic              mem_we_o,
  output logic              mem_re_o,
  output logic [AddrW-1:0]  mem_addr_o,
  output crb_flags_t        flags_o
);

  localparam logic [PtrW-1:0] PtrFirst = PtrW'(1);
  localparam logic [PtrW-1:0] PtrLast  = PtrW'(RING_DEPTH - 1);

  logic [PtrW-1:0] wp_q [CHANNEL_COUNT];
  logic [PtrW-1:0] rp_q [CHANNEL_COUNT];

  logic            ch_ok;
  logic [IdxW-1:0] idx;
  logic [PtrW-1:0] wp, rp, wp_next, rp_next, wp_adv, rp_adv, ptr_sel;
  logic            is_empty, is_full;

  assign ch_ok  = (int'(channel_i) < CHANNEL_COUNT);
  assign idx    = IdxW'(channel_i);
  assign wp     = ch_ok ? wp_q[idx] : PtrFirst;
  assign rp     = ch_ok ? rp_q[idx] : PtrFirst;
  assign wp_adv = (wp >= PtrLast) ? PtrFirst : wp + PtrW'(1);
  assign rp_adv = (rp >= PtrLast) ? PtrFirst : rp + PtrW'(1);

  assign is_empty = (wp == rp);
  assign is_full  = (wp_adv == rp);

  always_comb begin
    wp_next  = wp;
    rp_next  = rp;
    mem_we_o = 1'b0;
    mem_re_o = 1'b0;
    flags_o  = '0;
    unique case (op_i)
      OP_PUSH: begin
        if (is_full) begin
          flags_o.dropped = ch_ok;
        end else begin
          wp_next  = wp_adv;
          mem_we_o = en_i && ch_ok;
        end
      end
      OP_POP: begin
        if (!is_empty) begin
          rp_next          = rp_adv;
          flags_o.got_byte = ch_ok;
          mem_re_o         = en_i && ch_ok;
        end
      end
      OP_FLUSH: begin
        wp_next = PtrFirst;
        rp_next = PtrFirst;
      end
      default: begin
      end
    endcase
    flags_o.not_empty = ch_ok && (wp_next != rp_next);
  end

  assign ptr_sel    = (op_i == OP_PUSH) ? wp : rp;
  assign mem_addr_o = AddrW'(AddrW'(idx) * AddrW'(RING_DEPTH)) + AddrW'(ptr_sel);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNEL_COUNT; i++) begin
        wp_q[i] <= PtrFirst;
        rp_q[i] <= PtrFirst;
      end
    end else if (en_i && ch_ok) begin
      wp_q[idx] <= wp_next;
      rp_q[idx] <= rp_next;
    end
  end

endmodule

// ===== sv/multi_channel_receive_ring_buffer_core.sv =====
`timescale 1ns / 1ps
// Pipeline: an accepted word passes the s1 stage (memory read and held flags)
// and then the output register, where it waits while out_o.ready is low.
// Throughput: one word per cycle unless the output stalls; pointers update in
// the accept cycle, the storage memory is read or written once; back-to-back words never collide.
// Reset (async, active low) sets every channel's read and write pointers to 1
// and empties the pipeline; the byte store itself is not cleared.

module multi_channel_receive_ring_buffer_core import crb_pkg::*; #(
  parameter int RING_DEPTH    = CRB_RING_DEPTH,
  parameter int CHANNEL_COUNT = CRB_CHANNEL_COUNT
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  crb_in_if.sink   in_i,
  crb_out_if.source out_o
);

  localparam int AddrW = $clog2(RING_DEPTH * CHANNEL_COUNT);

  logic              accept, adv_s1;
  logic              mem_we, mem_re;
  logic [AddrW-1:0]  mem_addr;
  logic [BYTE_W-1:0] mem_rdata;
  crb_flags_t        flags;

  logic              s1_valid_q;
  crb_flags_t        s1_flags_q;
  logic              out_valid_q;
  crb_flags_t        out_flags_q;
  logic [BYTE_W-1:0] out_byte_q;

  assign adv_s1     = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || adv_s1;
  assign accept     = in_i.valid && in_i.ready;

  crb_ptr_ctrl #(
    .RING_DEPTH    (RING_DEPTH),
    .CHANNEL_COUNT (CHANNEL_COUNT)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (accept),
    .op_i       (in_i.op),
    .channel_i  (in_i.channel),
    .mem_we_o   (mem_we),
    .mem_re_o   (mem_re),
    .mem_addr_o (mem_addr),
    .flags_o    (flags)
  );

  crb_ring_mem #(
    .RING_DEPTH    (RING_DEPTH),
    .CHANNEL_COUNT (CHANNEL_COUNT)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .re_i    (mem_re),
    .addr_i  (mem_addr),
    .wdata_i (in_i.received_byte),
    .rdata_o (mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (adv_s1) begin
        s1_valid_q <= 1'b0;
      end
      if (adv_s1) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // hold flags beside the memory read; read data is stable until the next accept
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_flags_q <= flags;
    end
    if (adv_s1) begin
      out_flags_q <= s1_flags_q;
      out_byte_q  <= s1_flags_q.got_byte ? mem_rdata : '0;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.byte_out  = out_byte_q;
  assign out_o.got_byte  = out_flags_q.got_byte;
  assign out_o.dropped   = out_flags_q.dropped;
  assign out_o.not_empty = out_flags_q.not_empty;

endmodule
